// ===== src/triangle_point_depth_interp_assert.svh =====
// Assertion macros shared by the triangle depth interpolator checks.
`ifndef TRIANGLE_POINT_DEPTH_INTERP_ASSERT_SVH
`define TRIANGLE_POINT_DEPTH_INTERP_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TPDI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define TPDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tpdi_pkg.sv =====
// Types and constants shared by the triangle depth interpolator modules.
package tpdi_pkg;

	localparam int CW         = 24;               // coordinate and depth width
	localparam int DW         = CW + 1;           // coordinate difference width
	localparam int PW         = 2 * DW;           // cross product term width
	localparam int EW         = PW + 1;           // edge function width
	localparam int WFRAC      = 24;               // weight fraction bits
	localparam int PRW        = WFRAC + 1 + CW;   // weight times depth width
	localparam int AW         = PRW + 2;          // blend accumulator width
	localparam int N_IN       = 11;               // fields in one input item
	localparam int S_TDATA_W  = ((N_IN * CW + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((CW + 7) / 8) * 8;

	localparam logic [WFRAC:0] WONE = {1'b1, {WFRAC{1'b0}}};

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [CW-1:0]        depth_t;

	typedef struct packed {
		coord_t px;
		coord_t pz;
		coord_t ax;
		coord_t az;
		depth_t ad;
		coord_t bx;
		coord_t bz;
		depth_t bd;
		coord_t cx;
		coord_t cz;
		depth_t cd;
	} tri_t;

	typedef struct packed {
		depth_t da;
		depth_t db;
		depth_t dc;
	} dtrio_t;

	// One item inside the divider: two fractions share one denominator.
	typedef struct packed {
		logic              hit;
		logic [EW-1:0]     den;
		logic [EW-1:0]     rem_a;
		logic [EW-1:0]     rem_b;
		logic [WFRAC-1:0]  q_a;
		logic [WFRAC-1:0]  q_b;
		dtrio_t            dep;
	} lane_t;

endpackage

// ===== src/tpdi_edge.sv =====
// Edge functions, doubled area, inside test and divider operands.
module tpdi_edge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  tpdi_pkg::tri_t  in_tri,
	output logic            out_valid,
	output tpdi_pkg::lane_t out_lane
);
	import tpdi_pkg::*;

	function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
		return v[EW-1] ? EW'(-v) : EW'(v);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [DW-1:0] bax_s1, baz_s1, cax_s1, caz_s1, pax_s1, paz_s1;
	logic signed [DW-1:0] acx_s1, acz_s1, pcx_s1, pcz_s1;
	logic signed [DW-1:0] cbx_s1, cbz_s1, pbx_s1, pbz_s1;
	dtrio_t dep_s1, dep_s2, dep_s3;

	logic signed [PW-1:0] ar0_s2, ar1_s2, ab0_s2, ab1_s2;
	logic signed [PW-1:0] ca0_s2, ca1_s2, bc0_s2, bc1_s2;

	logic signed [EW-1:0] area_s3, eab_s3, eca_s3, ebc_s3;

	logic  same_sign;
	lane_t lane_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: coordinate differences.
	always_ff @(posedge clk) begin
		if (adv) begin
			bax_s1 <= DW'(in_tri.bx) - DW'(in_tri.ax);
			baz_s1 <= DW'(in_tri.bz) - DW'(in_tri.az);
			cax_s1 <= DW'(in_tri.cx) - DW'(in_tri.ax);
			caz_s1 <= DW'(in_tri.cz) - DW'(in_tri.az);
			pax_s1 <= DW'(in_tri.px) - DW'(in_tri.ax);
			paz_s1 <= DW'(in_tri.pz) - DW'(in_tri.az);
			acx_s1 <= DW'(in_tri.ax) - DW'(in_tri.cx);
			acz_s1 <= DW'(in_tri.az) - DW'(in_tri.cz);
			pcx_s1 <= DW'(in_tri.px) - DW'(in_tri.cx);
			pcz_s1 <= DW'(in_tri.pz) - DW'(in_tri.cz);
			cbx_s1 <= DW'(in_tri.cx) - DW'(in_tri.bx);
			cbz_s1 <= DW'(in_tri.cz) - DW'(in_tri.bz);
			pbx_s1 <= DW'(in_tri.px) - DW'(in_tri.bx);
			pbz_s1 <= DW'(in_tri.pz) - DW'(in_tri.bz);
			dep_s1 <= '{da: in_tri.ad, db: in_tri.bd, dc: in_tri.cd};
		end
	end

	// Stage 2: cross product terms.
	always_ff @(posedge clk) begin
		if (adv) begin
			ar0_s2 <= PW'(bax_s1) * PW'(caz_s1);
			ar1_s2 <= PW'(baz_s1) * PW'(cax_s1);
			ab0_s2 <= PW'(bax_s1) * PW'(paz_s1);
			ab1_s2 <= PW'(baz_s1) * PW'(pax_s1);
			ca0_s2 <= PW'(acx_s1) * PW'(pcz_s1);
			ca1_s2 <= PW'(acz_s1) * PW'(pcx_s1);
			bc0_s2 <= PW'(cbx_s1) * PW'(pbz_s1);
			bc1_s2 <= PW'(cbz_s1) * PW'(pbx_s1);
			dep_s2 <= dep_s1;
		end
	end

	// Stage 3: edge functions and doubled area.
	always_ff @(posedge clk) begin
		if (adv) begin
			area_s3 <= EW'(ar0_s2) - EW'(ar1_s2);
			eab_s3  <= EW'(ab0_s2) - EW'(ab1_s2);
			eca_s3  <= EW'(ca0_s2) - EW'(ca1_s2);
			ebc_s3  <= EW'(bc0_s2) - EW'(bc1_s2);
			dep_s3  <= dep_s2;
		end
	end

	// Strict sign agreement; zero area or a zero edge fails.
	assign same_sign = (area_s3 != '0) && (eab_s3 != '0) && (eca_s3 != '0) &&
		(ebc_s3 != '0) && (eab_s3[EW-1] == area_s3[EW-1]) &&
		(eca_s3[EW-1] == area_s3[EW-1]) && (ebc_s3[EW-1] == area_s3[EW-1]);

	// Stage 4: magnitudes. The BC edge weighs vertex A, the CA edge vertex B.
	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s4.hit   <= same_sign;
			lane_s4.den   <= mag(area_s3);
			lane_s4.rem_a <= mag(ebc_s3);
			lane_s4.rem_b <= mag(eca_s3);
			lane_s4.q_a   <= '0;
			lane_s4.q_b   <= '0;
			lane_s4.dep   <= dep_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_lane  = lane_s4;

endmodule

// ===== src/tpdi_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for both weights.
module tpdi_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  tpdi_pkg::lane_t in_lane,
	output logic            out_valid,
	output tpdi_pkg::lane_t out_lane
);
	import tpdi_pkg::*;

	function automatic lane_t step(input lane_t l);
		logic [EW:0] ra;
		logic [EW:0] rb;
		logic [EW:0] dd;
		lane_t       o;
		o  = l;
		ra = {l.rem_a, 1'b0};
		rb = {l.rem_b, 1'b0};
		dd = {1'b0, l.den};
		if (ra >= dd) begin
			o.rem_a = EW'(ra - dd);
			o.q_a   = {l.q_a[WFRAC-2:0], 1'b1};
		end else begin
			o.rem_a = ra[EW-1:0];
			o.q_a   = {l.q_a[WFRAC-2:0], 1'b0};
		end
		if (rb >= dd) begin
			o.rem_b = EW'(rb - dd);
			o.q_b   = {l.q_b[WFRAC-2:0], 1'b1};
		end else begin
			o.rem_b = rb[EW-1:0];
			o.q_b   = {l.q_b[WFRAC-2:0], 1'b0};
		end
		return o;
	endfunction

	logic [WFRAC-1:0] v_s;
	lane_t            lane_s [WFRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[WFRAC-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s[0] <= step(in_lane);
			for (int k = 1; k < WFRAC; k++) begin
				lane_s[k] <= step(lane_s[k-1]);
			end
		end
	end

	assign out_valid = v_s[WFRAC-1];
	assign out_lane  = lane_s[WFRAC-1];

endmodule

// ===== src/tpdi_blend.sv =====
// Barycentric depth blend, rounding, saturation and the output register.
module tpdi_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  tpdi_pkg::lane_t               in_lane,
	output logic                          out_valid,
	output logic                          out_inside,
	output logic [tpdi_pkg::CW-1:0]       out_depth
);
	import tpdi_pkg::*;

	logic             v_s1, v_s2;
	logic             inside_s1, inside_s2;
	logic [WFRAC:0]   w3;
	logic [PRW-1:0]   p1_s1, p2_s1, p3_s1;
	logic [AW-1:0]    acc;
	logic [AW-WFRAC-1:0] dep;
	logic [CW-1:0]    dep_sat;
	logic [CW-1:0]    depth_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Third weight closes the sum to exactly one.
	assign w3 = WONE - (WFRAC+1)'(in_lane.q_a) - (WFRAC+1)'(in_lane.q_b);

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s1 <= in_lane.hit;
			p1_s1     <= PRW'(in_lane.q_a) * PRW'(in_lane.dep.da);
			p2_s1     <= PRW'(in_lane.q_b) * PRW'(in_lane.dep.db);
			p3_s1     <= PRW'(w3) * PRW'(in_lane.dep.dc);
		end
	end

	// Round half up, then clamp to the depth range.
	assign acc = AW'(p1_s1) + AW'(p2_s1) + AW'(p3_s1) + AW'(WONE >> 1);
	assign dep = acc[AW-1:WFRAC];
	assign dep_sat = (dep[AW-WFRAC-1:CW] != '0) ? {CW{1'b1}} : dep[CW-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s2 <= inside_s1;
			depth_s2  <= inside_s1 ? dep_sat : '0;
		end
	end

	assign out_valid  = v_s2;
	assign out_inside = inside_s2;
	assign out_depth  = depth_s2;

endmodule

// ===== src/triangle_point_depth_interp.sv =====
// Top level of the point-in-triangle test with barycentric depth blend.
//
// Usage: drive one item per cycle on the s_axis channel: a sample point and
// three vertices (x, z, depth), all Q16.8. Each item yields exactly one item
// on m_axis: tuser is 1 when the point lies strictly inside a non-degenerate
// triangle, and tdata then holds the blended depth, rounded half up and
// saturated; otherwise both are zero. Points on an edge count as outside.
// The pipeline has 4 stages of differences, cross products, edge
// functions and magnitudes, 24 divider stages that each settle one bit of
// both weights, and 2 blend stages ending in the output register.
// It takes one item per cycle while the receiver does not stall.
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken, so s_axis_tready follows m_axis_tready
// while a result waits and stays high while the output is empty.
// A receiver stall freezes every stage in place; nothing is dropped or
// repeated. Reset clears all valid bits; data registers keep garbage that
// is never shown.
module triangle_point_depth_interp (
	input  logic                               clk,
	input  logic                               arst_n,
	// point_x, point_z, a_x, a_z, a_depth, b_x, b_z, b_depth, c_x, c_z, c_depth
	input  logic [tpdi_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// depth_out
	output logic [tpdi_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// inside_res
	output logic                               m_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready
);
	import tpdi_pkg::*;

	logic   adv;
	tri_t   in_tri;
	logic   edge_valid, div_valid;
	lane_t  edge_lane, div_lane;
	logic [CW-1:0] depth;

	// Advance everything when the output slot is free or being emptied.
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// Unpack the input item, first field in the lowest bits.
	always_comb begin
		in_tri.px = s_axis_tdata[0*CW +: CW];
		in_tri.pz = s_axis_tdata[1*CW +: CW];
		in_tri.ax = s_axis_tdata[2*CW +: CW];
		in_tri.az = s_axis_tdata[3*CW +: CW];
		in_tri.ad = s_axis_tdata[4*CW +: CW];
		in_tri.bx = s_axis_tdata[5*CW +: CW];
		in_tri.bz = s_axis_tdata[6*CW +: CW];
		in_tri.bd = s_axis_tdata[7*CW +: CW];
		in_tri.cx = s_axis_tdata[8*CW +: CW];
		in_tri.cz = s_axis_tdata[9*CW +: CW];
		in_tri.cd = s_axis_tdata[10*CW +: CW];
	end

	// Edge functions, area and inside decision.
	tpdi_edge u_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_axis_tvalid),
		.in_tri    (in_tri),
		.out_valid (edge_valid),
		.out_lane  (edge_lane)
	);

	// Two weight fractions over the common area.
	tpdi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (edge_valid),
		.in_lane   (edge_lane),
		.out_valid (div_valid),
		.out_lane  (div_lane)
	);

	// Weighted depth sum and output register.
	tpdi_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (div_valid),
		.in_lane    (div_lane),
		.out_valid  (m_axis_tvalid),
		.out_inside (m_axis_tuser),
		.out_depth  (depth)
	);

	assign m_axis_tdata = M_TDATA_W'(depth);

endmodule

// ===== src/tpdi_checker.sv =====
// Port-level checks for the triangle depth interpolator and their binding.
`include "triangle_point_depth_interp_assert.svh"

module tpdi_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tready,
	input  logic [tpdi_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input  logic                           m_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready
);

	// An outside point always reports zero depth.
	`TPDI_ASSERT_SAME(a_outside_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "outside item with nonzero depth")

	// Input side is ready exactly when the output slot can move.
	`TPDI_ASSERT_SAME(a_ready_follows, clk, arst_n, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not track output slot")

	// A stalled result holds its value.
	`TPDI_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// Leaving reset shows no stale result.
	`TPDI_ASSERT_SAME(a_reset_empty, clk, arst_n, $rose(arst_n), !m_axis_tvalid, "result valid right after reset")

endmodule

bind triangle_point_depth_interp tpdi_checker u_tpdi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
